FILE: hdl/gbrw_pkg.sv
// ----------------------------------------------------------------------------
// gbrw_pkg
// Shared types and constants for the 5x5 RGB Gaussian blur window.
// ----------------------------------------------------------------------------
package gbrw_pkg;

    // Kernel geometry (5x5, radius 2, crop margin 3)
    localparam int KSIZE   = 5;
    localparam int KRAD    = (KSIZE - 1) / 2;
    localparam int KMARGIN = KRAD + 1;
    localparam int NLINES  = KSIZE - 1;

    // Line store geometry
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 12;
    localparam int WID_W     = 11;

    // Pixel and arithmetic widths
    localparam int CH_W   = 8;
    localparam int NCH    = 3;
    localparam int PIX_W  = CH_W * NCH;
    localparam int WT_W   = 16;
    localparam int FRAC_W = 16;
    localparam int NCLS   = 6;
    localparam int CSUM_W = CH_W + 3;          // up to eight taps per class
    localparam int PROD_W = CSUM_W + WT_W;
    localparam int ACC_W  = PROD_W + 3;        // six products

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [PIX_W-1:0] t_pixel;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_D00    = 3'd2,
        REG_D01    = 3'd3,
        REG_D02    = 3'd4,
        REG_D11    = 3'd5,
        REG_D12    = 3'd6,
        REG_D22    = 3'd7
    } t_reg_idx;

    // Distance classes, index into weight and class-sum arrays
    localparam int CLS_D00 = 0;
    localparam int CLS_D01 = 1;
    localparam int CLS_D02 = 2;
    localparam int CLS_D11 = 3;
    localparam int CLS_D12 = 4;
    localparam int CLS_D22 = 5;

    localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
    localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(480);

endpackage

FILE: hdl/gaussian_blur_rgb_window.sv
// ----------------------------------------------------------------------------
// gaussian_blur_rgb_window - streaming 5x5 Gaussian blur over RGB pixels
// Throughput: one pixel per cycle while the output is not stalled; the line
// store is one 96-bit word per column, read and written once per pixel,
// with a bypass for back-to-back accesses to the same column. Reset clears
// counters, valids and configuration registers (width 640, height 480,
// weights 0); the line store is not cleared.
// ----------------------------------------------------------------------------
module gaussian_blur_rgb_window (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [gbrw_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [gbrw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // pixel in
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [gbrw_pkg::CH_W-1:0]         i_pixel_red,
    input  logic [gbrw_pkg::CH_W-1:0]         i_pixel_green,
    input  logic [gbrw_pkg::CH_W-1:0]         i_pixel_blue,
    // result out
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [gbrw_pkg::CH_W-1:0]         o_blur_red,
    output logic [gbrw_pkg::CH_W-1:0]         o_blur_green,
    output logic [gbrw_pkg::CH_W-1:0]         o_blur_blue,
    output logic                              o_frame_end
);

    localparam int LW = gbrw_pkg::NLINES * gbrw_pkg::PIX_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [gbrw_pkg::WID_W-1:0] r_width;
    logic [gbrw_pkg::ROW_W-1:0] r_height;
    logic [gbrw_pkg::WT_W-1:0]  r_wt [gbrw_pkg::NCLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= gbrw_pkg::WIDTH_RESET;
            r_height <= gbrw_pkg::HEIGHT_RESET;
            for (int k = 0; k < gbrw_pkg::NCLS; k++) begin
                r_wt[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (gbrw_pkg::t_reg_idx'(i_cfg_addr))
                gbrw_pkg::REG_WIDTH:  r_width  <= i_cfg_data[gbrw_pkg::WID_W-1:0];
                gbrw_pkg::REG_HEIGHT: r_height <= i_cfg_data[gbrw_pkg::ROW_W-1:0];
                gbrw_pkg::REG_D00:    r_wt[gbrw_pkg::CLS_D00] <= i_cfg_data;
                gbrw_pkg::REG_D01:    r_wt[gbrw_pkg::CLS_D01] <= i_cfg_data;
                gbrw_pkg::REG_D02:    r_wt[gbrw_pkg::CLS_D02] <= i_cfg_data;
                gbrw_pkg::REG_D11:    r_wt[gbrw_pkg::CLS_D11] <= i_cfg_data;
                gbrw_pkg::REG_D12:    r_wt[gbrw_pkg::CLS_D12] <= i_cfg_data;
                gbrw_pkg::REG_D22:    r_wt[gbrw_pkg::CLS_D22] <= i_cfg_data;
                default:              r_width  <= r_width;
            endcase
        end
    end

    // Effective frame size: width clamped to 1..MAX_WIDTH, height at least 1
    logic [gbrw_pkg::WID_W-1:0] w_eff;
    logic [gbrw_pkg::ROW_W-1:0] h_eff;

    always_comb begin
        if (r_width > gbrw_pkg::WID_W'(gbrw_pkg::MAX_WIDTH)) begin
            w_eff = gbrw_pkg::WID_W'(gbrw_pkg::MAX_WIDTH);
        end else if (r_width == '0) begin
            w_eff = gbrw_pkg::WID_W'(1);
        end else begin
            w_eff = r_width;
        end
        h_eff = (r_height == '0) ? gbrw_pkg::ROW_W'(1) : r_height;
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipe advances unless the output register
    // holds a beat that downstream is stalling. Empty stages are bubbles.
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic en;
    logic accept;

    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;
    assign accept  = i_valid && en;

    // ------------------------------------------------------------------
    // Raster position counters (advance on every accepted beat)
    // ------------------------------------------------------------------
    logic [gbrw_pkg::COL_W-1:0] r_col;
    logic [gbrw_pkg::ROW_W-1:0] r_row;
    logic [gbrw_pkg::COL_W-1:0] n_col;
    logic [gbrw_pkg::ROW_W-1:0] n_row;
    logic [gbrw_pkg::WID_W-1:0] col_inc;
    logic [gbrw_pkg::ROW_W:0]   row_inc;

    always_comb begin
        col_inc = gbrw_pkg::WID_W'(r_col) + gbrw_pkg::WID_W'(1);
        row_inc = {1'b0, r_row} + (gbrw_pkg::ROW_W+1)'(1);
        n_col   = col_inc[gbrw_pkg::COL_W-1:0];
        n_row   = r_row;
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[gbrw_pkg::ROW_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register plus line store read at the current column
    // ------------------------------------------------------------------
    logic                        r_s1_vld;
    gbrw_pkg::t_pixel            r_s1_pix;
    logic [gbrw_pkg::COL_W-1:0]  r_s1_col;
    logic [gbrw_pkg::ROW_W-1:0]  r_s1_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix <= {i_pixel_red, i_pixel_green, i_pixel_blue};
            r_s1_col <= r_col;
            r_s1_row <= r_row;
        end
    end

    // Line store: one word per column, line k at bits [k*PIX_W +: PIX_W],
    // line 0 the oldest row.
    logic [LW-1:0] r_mem [gbrw_pkg::MAX_WIDTH];
    logic [LW-1:0] r_rd_q;
    logic [LW-1:0] r_fwd_data;
    logic          r_fwd_hit;
    logic [LW-1:0] rd_word;
    logic [LW-1:0] wr_word;
    logic          wr_en;

    assign wr_en   = en && r_s1_vld;
    assign rd_word = r_fwd_hit ? r_fwd_data : r_rd_q;
    // each line moves up one: line k takes line k+1, the last takes the pixel
    assign wr_word = {r_s1_pix, rd_word[LW-1:gbrw_pkg::PIX_W]};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_s1_col] <= wr_word;
        end
        if (en) begin
            r_rd_q     <= r_mem[r_col];
            r_fwd_data <= wr_word;
        end
    end

    // same-column bypass (one-pixel-wide rows)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (en) begin
            r_fwd_hit <= wr_en && (r_s1_col == r_col);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: window shift and output decision
    // ------------------------------------------------------------------
    gbrw_pkg::t_pixel           r_win [gbrw_pkg::KSIZE][gbrw_pkg::KSIZE];
    gbrw_pkg::t_pixel           colv  [gbrw_pkg::KSIZE];
    logic                       r_s2_vld;
    logic                       r_s2_last;
    logic                       produce;
    logic                       last;
    logic [gbrw_pkg::WID_W-1:0] s1_col_p2;
    logic [gbrw_pkg::ROW_W:0]   s1_row_p2;

    always_comb begin
        for (int k = 0; k < gbrw_pkg::NLINES; k++) begin
            colv[k] = rd_word[k*gbrw_pkg::PIX_W +: gbrw_pkg::PIX_W];
        end
        colv[gbrw_pkg::KSIZE-1] = r_s1_pix;
    end

    // centre must sit at least KMARGIN from every border
    always_comb begin
        s1_col_p2 = gbrw_pkg::WID_W'(r_s1_col) + gbrw_pkg::WID_W'(2);
        s1_row_p2 = {1'b0, r_s1_row} + (gbrw_pkg::ROW_W+1)'(2);
        produce   = (r_s1_col >= gbrw_pkg::COL_W'(gbrw_pkg::KSIZE))
                 && (s1_col_p2 <= w_eff)
                 && (r_s1_row >= gbrw_pkg::ROW_W'(gbrw_pkg::KSIZE))
                 && (s1_row_p2 <= {1'b0, h_eff});
        last      = (s1_col_p2 == w_eff) && (s1_row_p2 == {1'b0, h_eff});
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            for (int i = 0; i < gbrw_pkg::KSIZE; i++) begin
                for (int j = 0; j < gbrw_pkg::KSIZE - 1; j++) begin
                    r_win[i][j] <= r_win[i][j+1];
                end
                r_win[i][gbrw_pkg::KSIZE-1] <= colv[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld  <= 1'b0;
            r_s2_last <= 1'b0;
        end else if (en) begin
            r_s2_vld  <= r_s1_vld && produce;
            r_s2_last <= last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: per-channel sums of taps that share a weight (symmetry)
    // ------------------------------------------------------------------
    logic [gbrw_pkg::CSUM_W-1:0] n_csum [gbrw_pkg::NCH][gbrw_pkg::NCLS];
    logic [gbrw_pkg::CSUM_W-1:0] r_csum [gbrw_pkg::NCH][gbrw_pkg::NCLS];
    logic                        r_s3_vld;
    logic                        r_s3_last;

    function automatic logic [gbrw_pkg::CSUM_W-1:0] tap(
        input gbrw_pkg::t_pixel p,
        input int               c
    );
        return gbrw_pkg::CSUM_W'(p[c*gbrw_pkg::CH_W +: gbrw_pkg::CH_W]);
    endfunction

    always_comb begin
        for (int c = 0; c < gbrw_pkg::NCH; c++) begin
            n_csum[c][gbrw_pkg::CLS_D00] = tap(r_win[2][2], c);
            n_csum[c][gbrw_pkg::CLS_D01] = tap(r_win[1][2], c) + tap(r_win[3][2], c)
                                         + tap(r_win[2][1], c) + tap(r_win[2][3], c);
            n_csum[c][gbrw_pkg::CLS_D02] = tap(r_win[0][2], c) + tap(r_win[4][2], c)
                                         + tap(r_win[2][0], c) + tap(r_win[2][4], c);
            n_csum[c][gbrw_pkg::CLS_D11] = tap(r_win[1][1], c) + tap(r_win[1][3], c)
                                         + tap(r_win[3][1], c) + tap(r_win[3][3], c);
            n_csum[c][gbrw_pkg::CLS_D12] = tap(r_win[0][1], c) + tap(r_win[0][3], c)
                                         + tap(r_win[4][1], c) + tap(r_win[4][3], c)
                                         + tap(r_win[1][0], c) + tap(r_win[3][0], c)
                                         + tap(r_win[1][4], c) + tap(r_win[3][4], c);
            n_csum[c][gbrw_pkg::CLS_D22] = tap(r_win[0][0], c) + tap(r_win[0][4], c)
                                         + tap(r_win[4][0], c) + tap(r_win[4][4], c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_csum <= n_csum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld  <= 1'b0;
            r_s3_last <= 1'b0;
        end else if (en) begin
            r_s3_vld  <= r_s2_vld;
            r_s3_last <= r_s2_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: class sum times Q0.16 weight (18 independent 11x16 products)
    // ------------------------------------------------------------------
    logic [gbrw_pkg::PROD_W-1:0] r_prod [gbrw_pkg::NCH][gbrw_pkg::NCLS];
    logic                        r_s4_vld;
    logic                        r_s4_last;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < gbrw_pkg::NCH; c++) begin
                for (int k = 0; k < gbrw_pkg::NCLS; k++) begin
                    r_prod[c][k] <= gbrw_pkg::PROD_W'(r_csum[c][k])
                                  * gbrw_pkg::PROD_W'(r_wt[k]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld  <= 1'b0;
            r_s4_last <= 1'b0;
        end else if (en) begin
            r_s4_vld  <= r_s3_vld;
            r_s4_last <= r_s3_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: accumulate, drop the fraction, clip to 255; output register
    // ------------------------------------------------------------------
    logic [gbrw_pkg::ACC_W-1:0] acc     [gbrw_pkg::NCH];
    logic [gbrw_pkg::CH_W-1:0]  n_chan  [gbrw_pkg::NCH];
    logic [gbrw_pkg::CH_W-1:0]  r_chan  [gbrw_pkg::NCH];
    logic                       r_out_last;

    always_comb begin
        for (int c = 0; c < gbrw_pkg::NCH; c++) begin
            acc[c] = '0;
            for (int k = 0; k < gbrw_pkg::NCLS; k++) begin
                acc[c] = acc[c] + gbrw_pkg::ACC_W'(r_prod[c][k]);
            end
            if (acc[c][gbrw_pkg::ACC_W-1:gbrw_pkg::FRAC_W+gbrw_pkg::CH_W] != '0) begin
                n_chan[c] = '1;
            end else begin
                n_chan[c] = acc[c][gbrw_pkg::FRAC_W +: gbrw_pkg::CH_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_chan     <= n_chan;
            r_out_last <= r_s4_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s4_vld;
        end
    end

    // channel 2 is red, 1 green, 0 blue
    assign o_valid      = r_out_valid;
    assign o_blur_red   = r_chan[2];
    assign o_blur_green = r_chan[1];
    assign o_blur_blue  = r_chan[0];
    assign o_frame_end  = r_out_valid && r_out_last;

endmodule

FILE: hdl/gbrw_checker.sv
// ----------------------------------------------------------------------------
// gbrw_checker
// Port-level checks for the Gaussian blur window, bound to the top level.
// ----------------------------------------------------------------------------
module gbrw_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [gbrw_pkg::CH_W-1:0]  o_blur_red,
    input logic [gbrw_pkg::CH_W-1:0]  o_blur_green,
    input logic [gbrw_pkg::CH_W-1:0]  o_blur_blue,
    input logic                       o_frame_end
);

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_blur_red)
            && $stable(o_blur_green) && $stable(o_blur_blue)
            && $stable(o_frame_end))
        else $error("result beat changed while stalled");

    // a stalled full output register must push back on the input
    a_backpressure: assert property (@(posedge i_clk)
        o_valid && i_stall |-> o_stall)
        else $error("input taken while output blocked");

    // an empty output register never stalls the input side
    a_no_idle_stall: assert property (@(posedge i_clk)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    // frame end only marks a real beat
    a_end_valid: assert property (@(posedge i_clk)
        o_frame_end |-> o_valid)
        else $error("frame end without beat");

endmodule

bind gaussian_blur_rgb_window gbrw_checker u_gbrw_checker (.*);
